@@ rtl/dda_line_rasteriser_top_defines.svh @@
// Assertion macros shared by the line rasteriser RTL.
// Every module that uses them has a clock named clk and a reset named rst.
`ifndef DDA_LINE_RASTERISER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERISER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DDA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line rasteriser assertion failed");

// Next-cycle implication, checked outside reset.
`define DDA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line rasteriser assertion failed");

`endif

@@ rtl/dda_pkg.sv @@
// Package for the DDA line rasteriser: default sizes and the divider status type.
// No dependencies.
`timescale 1ns / 1ps

package dda_pkg;

  // Default coordinate width and number of fraction bits of the position.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Status reported by the shared step divider.
  typedef struct packed {
    logic busy;
    logic done;
  } dda_div_stat_t;

endpackage

@@ rtl/dda_if.sv @@
// Valid/ready channel interfaces for line requests and emitted pixels.
// Depends on dda_pkg for default widths.
`timescale 1ns / 1ps

interface dda_req_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_pix_if #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

@@ rtl/dda_div.sv @@
// Shared restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on dda_pkg and dda_line_rasteriser_top_defines.svh.
`timescale 1ns / 1ps
`include "dda_line_rasteriser_top_defines.svh"

module dda_div #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [COORD_BITS-1:0]           dividend,
  input  logic [COORD_BITS-1:0]           divisor,
  output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
  output dda_pkg::dda_div_stat_t          stat
);

  localparam int DVD_W = COORD_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] dvs;
  logic [DVD_W-1:0]      quo;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS+1:0] diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[COORD_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVD_W);
      rem  <= '0;
      dvs  <= divisor;
      quo  <= {dividend, {FRAC_BITS{1'b0}}};
    end else if (busy) begin
      rem  <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo  <= {quo[DVD_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `DDA_ASSERT_NXT(a_start_busy, start, busy)
  `DDA_ASSERT_IMP(a_busy_count, busy, cnt != '0)
  `DDA_ASSERT_NXT(a_done_idle, done, !done)

endmodule

@@ rtl/dda_line_rasteriser_top.sv @@
// DDA line rasteriser top level: request sequencer, position registers and pixel output.
// Depends on dda_pkg, dda_if, dda_div and dda_line_rasteriser_top_defines.svh.
`timescale 1ns / 1ps
`include "dda_line_rasteriser_top_defines.svh"

// Usage:
// The req channel takes one transaction per request. req_type 0 starts a new line
// from (start_x, start_y) to (end_x, end_y) and yields its first pixel; req_type 1
// advances the active line and yields the next pixel, or nothing if no line is active.
// The pix channel carries one pixel per result, with last_pixel set on the final one,
// which is always the stored endpoint.
// A start passes from acceptance through the delta, magnitude and span steps and the
// shared restoring divider, which forms the x step and then the y step at one quotient
// bit per cycle, before the pixel is loaded into the output register. An advance is
// accepted, adds the steps and loads the output.
// req.ready is high only while the sequencer waits for a request; a request may be
// accepted while the previous pixel still sits in the output register.
// If the receiver stalls, a finished pixel waits in the sequencer until the output
// register frees, and no new request is taken meanwhile.
// Reset is synchronous: it drops any active line and empties the output register.
module dda_line_rasteriser_top #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  dda_req_if.sink   req,
  dda_pix_if.source pix
);

  localparam int POS_W = COORD_BITS + FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DELTA     = 9'b000000010,
    S_MAG       = 9'b000000100,
    S_SPAN      = 9'b000001000,
    S_DIVX      = 9'b000010000,
    S_DIVY      = 9'b000100000,
    S_START_OUT = 9'b001000000,
    S_STEP      = 9'b010000000,
    S_ADV_OUT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        ax, ay, span;
  logic                         neg_x, neg_y;
  logic signed [POS_W-1:0]      pos_x, pos_y, inc_x, inc_y;
  logic [COORD_BITS-1:0]        pixels_left;
  logic                         line_active;

  logic                         out_valid;
  logic signed [COORD_BITS-1:0] out_x, out_y;
  logic                         out_last;

  logic                         in_fire;
  logic                         slot_free;
  logic                         out_load;

  logic                         div_start;
  logic [COORD_BITS-1:0]        div_dividend;
  logic [COORD_BITS-1:0]        div_divisor;
  logic [COORD_BITS-1:0]        span_c;
  logic [POS_W-1:0]             div_quo;
  dda_pkg::dda_div_stat_t       div_stat;

  logic signed [COORD_BITS:0]   dx_neg, dy_neg;
  logic signed [POS_W-1:0]      quo_s;
  logic signed [COORD_BITS-1:0] tx, ty;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign slot_free = !out_valid || pix.ready;
  assign out_load  = slot_free && ((state == S_START_OUT) || (state == S_ADV_OUT));

  // Magnitudes and span of the deltas.
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign span_c = (ax > ay) ? ax : ay;
  assign div_divisor = (span_c == '0) ? COORD_BITS'(1) : span_c;

  // The divider is started once for x and, when that finishes, once for y.
  assign div_start    = (state == S_SPAN) || ((state == S_DIVX) && div_stat.done);
  assign div_dividend = (state == S_SPAN) ? ax : ay;
  assign quo_s        = div_quo;

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quo),
    .stat    (div_stat)
  );

  // Truncate the position toward zero: floor, plus one for a negative value with a fraction.
  assign tx = pos_x[POS_W-1:FRAC_BITS]
              + COORD_BITS'(pos_x[POS_W-1] && (pos_x[FRAC_BITS-1:0] != '0));
  assign ty = pos_y[POS_W-1:FRAC_BITS]
              + COORD_BITS'(pos_y[POS_W-1] && (pos_y[FRAC_BITS-1:0] != '0));

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (!req.req_type) begin
            state_next = S_DELTA;
          end else if (line_active) begin
            state_next = S_STEP;
          end
        end
      end
      S_DELTA:     state_next = S_MAG;
      S_MAG:       state_next = S_SPAN;
      S_SPAN:      state_next = S_DIVX;
      S_DIVX:      if (div_stat.done) state_next = S_DIVY;
      S_DIVY:      if (div_stat.done) state_next = S_START_OUT;
      S_START_OUT: if (slot_free) state_next = S_IDLE;
      S_STEP:      state_next = S_ADV_OUT;
      S_ADV_OUT:   if (slot_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_START_OUT && slot_free) begin
        line_active <= (span != '0);
      end else if (state == S_ADV_OUT && slot_free && pixels_left == '0) begin
        line_active <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire && !req.req_type) begin
          sx <= req.start_x;
          sy <= req.start_y;
          ex <= req.end_x;
          ey <= req.end_y;
        end
      end
      S_DELTA: begin
        dx <= (COORD_BITS+1)'(ex) - (COORD_BITS+1)'(sx);
        dy <= (COORD_BITS+1)'(ey) - (COORD_BITS+1)'(sy);
      end
      S_MAG: begin
        neg_x <= dx[COORD_BITS];
        neg_y <= dy[COORD_BITS];
        ax    <= dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay    <= dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      end
      S_SPAN: begin
        span <= span_c;
      end
      S_DIVX: begin
        if (div_stat.done) inc_x <= neg_x ? -quo_s : quo_s;
      end
      S_DIVY: begin
        if (div_stat.done) inc_y <= neg_y ? -quo_s : quo_s;
      end
      S_START_OUT: begin
        if (slot_free) begin
          pos_x       <= {sx, {FRAC_BITS{1'b0}}};
          pos_y       <= {sy, {FRAC_BITS{1'b0}}};
          pixels_left <= span;
        end
      end
      S_STEP: begin
        pos_x       <= pos_x + inc_x;
        pos_y       <= pos_y + inc_y;
        pixels_left <= pixels_left - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded when a finished pixel meets a free slot.
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_START_OUT) begin
        out_x    <= (span == '0) ? ex : sx;
        out_y    <= (span == '0) ? ey : sy;
        out_last <= (span == '0);
      end else begin
        out_x    <= (pixels_left == '0) ? ex : tx;
        out_y    <= (pixels_left == '0) ? ey : ty;
        out_last <= (pixels_left == '0);
      end
    end
  end

  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_x;
  assign pix.pixel_y    = out_y;
  assign pix.last_pixel = out_last;

  `DDA_ASSERT_IMP(a_done_in_div, div_stat.done, (state == S_DIVX) || (state == S_DIVY))
  `DDA_ASSERT_IMP(a_idle_left, (state == S_IDLE) && line_active, pixels_left != '0)
  `DDA_ASSERT_NXT(a_last_ends, (state == S_ADV_OUT) && slot_free && (pixels_left == '0),
                  !line_active && out_valid && out_last)
  `DDA_ASSERT_IMP(a_ready_div_idle, req.ready, !div_stat.busy)

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the DDA line rasteriser: directed and random lines with
// random idling on both channels. Depends on dda_pkg, dda_if and dda_line_rasteriser_top.
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_BITS = dda_pkg::COORD_BITS_DEF;
  localparam int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF;
  localparam int POS_W      = COORD_BITS + FRAC_BITS;
  localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_W-1:0]      fixed_t;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t kind;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
  } line_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic clk;
  logic rst;

  dda_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
  dda_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

  dda_line_rasteriser_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .pix(pix_bus)
  );

  // Predicted rasteriser state.
  fixed_t              raster_pos_x;
  fixed_t              raster_pos_y;
  fixed_t              raster_step_x;
  fixed_t              raster_step_y;
  logic [COORD_BITS:0] pixels_to_go;
  logic                line_open;
  coord_t              line_end_x;
  coord_t              line_end_y;

  // Pixels predicted but not yet seen on the output channel.
  pixel_t pixels_due[$];

  int  fail_count      = 0;
  int  items_sent      = 0;
  bit  idle_on         = 1'b0;
  int  pix_hold_cycles = 0;

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Fixed-point step of one axis: delta scaled up by the fraction bits, divided by the
  // span and truncated toward zero.
  function automatic fixed_t axis_step(input int delta, input int span);
    int unsigned q;
    int unsigned d_mag;
    d_mag = (delta < 0) ? -delta : delta;
    q = (d_mag << FRAC_BITS) / span;
    return (delta < 0) ? -fixed_t'(q) : fixed_t'(q);
  endfunction

  // Integer part of a position, truncated toward zero.
  function automatic coord_t pos_to_coord(input fixed_t p);
    logic [POS_W-1:0] p_mag;
    logic [POS_W-1:0] whole;
    p_mag = p[POS_W-1] ? -p : p;
    whole = p_mag >> FRAC_BITS;
    return p[POS_W-1] ? coord_t'(-whole) : coord_t'(whole);
  endfunction

  // Advance the predicted state by one accepted request and queue the pixel it yields.
  function automatic void rasterise_req(input line_req_t r);
    int     dx;
    int     dy;
    int     span;
    pixel_t px;
    if (r.kind == REQ_START) begin
      dx = int'(r.ex) - int'(r.sx);
      dy = int'(r.ey) - int'(r.sy);
      span = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ? ((dx < 0) ? -dx : dx)
                                                            : ((dy < 0) ? -dy : dy);
      raster_step_x = axis_step(dx, (span > 0) ? span : 1);
      raster_step_y = axis_step(dy, (span > 0) ? span : 1);
      raster_pos_x  = {r.sx, {FRAC_BITS{1'b0}}};
      raster_pos_y  = {r.sy, {FRAC_BITS{1'b0}}};
      line_end_x    = r.ex;
      line_end_y    = r.ey;
      pixels_to_go  = (COORD_BITS+1)'(span);
      line_open     = (span > 0);
      // A single-point line is finished by its own start.
      if (span == 0) begin
        px = '{x: r.ex, y: r.ey, last: 1'b1};
      end else begin
        px = '{x: r.sx, y: r.sy, last: 1'b0};
      end
      pixels_due.push_back(px);
    end else if (line_open) begin
      raster_pos_x = raster_pos_x + raster_step_x;
      raster_pos_y = raster_pos_y + raster_step_y;
      pixels_to_go = pixels_to_go - 1'b1;
      // The final pixel is the stored endpoint, free of truncation drift.
      if (pixels_to_go == 0) begin
        line_open = 1'b0;
        px = '{x: line_end_x, y: line_end_y, last: 1'b1};
      end else begin
        px = '{x: pos_to_coord(raster_pos_x), y: pos_to_coord(raster_pos_y), last: 1'b0};
      end
      pixels_due.push_back(px);
    end
  endfunction

  // Request driver: valid stays high from one transaction to the next unless a gap is taken.
  initial begin
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_ADVANCE;
    req_bus.start_x  <= '0;
    req_bus.start_y  <= '0;
    req_bus.end_x    <= '0;
    req_bus.end_y    <= '0;
  end

  task automatic send_req(input req_kind_t kind, input coord_t sx, input coord_t sy,
                          input coord_t ex, input coord_t ey);
    line_req_t r;
    int        gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.start_x  <= sx;
    req_bus.start_y  <= sy;
    req_bus.end_x    <= ex;
    req_bus.end_y    <= ey;
    do @(posedge clk); while (!req_bus.ready);
    r = '{kind: kind, sx: sx, sy: sy, ex: ex, ey: ey};
    rasterise_req(r);
    items_sent++;
  endtask

  // Advance requests carry random coordinates, which the block must ignore.
  task automatic send_advance();
    send_req(REQ_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom));
  endtask

  // Drop valid and hold off until every predicted pixel has come out.
  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pixels_due.size() != 0);
  endtask

  // Output ready: long hold-offs when requested, random stall bursts when idling is on, else high.
  initial begin
    int stall_left;
    stall_left = 0;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pix_hold_cycles > 0) begin
        pix_hold_cycles--;
        pix_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= 1'b1;
      end
    end
  end

  // Compare every pixel transaction with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last=%0b", pix_bus.pixel_x, pix_bus.pixel_y,
               pix_bus.last_pixel);
        fail_count++;
      end else begin
        want = pixels_due.pop_front();
        if (pix_bus.pixel_x !== want.x) begin
          $error("pixel_x expected %0d actual %0d", want.x, pix_bus.pixel_x);
          fail_count++;
        end
        if (pix_bus.pixel_y !== want.y) begin
          $error("pixel_y expected %0d actual %0d", want.y, pix_bus.pixel_y);
          fail_count++;
        end
        if (pix_bus.last_pixel !== want.last) begin
          $error("last_pixel expected %0b actual %0b", want.last, pix_bus.last_pixel);
          fail_count++;
        end
      end
    end
  end

  // Endpoint near a base point, clamped to the coordinate range.
  function automatic coord_t near_point(input coord_t base, input int reach);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // One random episode: mostly complete short lines, some abandoned long lines and some
  // stray advances.
  task automatic draw_random_line(input int reach);
    coord_t sx;
    coord_t sy;
    int     pick;
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 3)) send_advance();
    end else if (pick == 1) begin
      send_req(REQ_START, sx, sy, coord_t'($urandom), coord_t'($urandom));
      repeat ($urandom_range(0, 6)) send_advance();
    end else begin
      send_req(REQ_START, sx, sy, near_point(sx, reach), near_point(sy, reach));
      while (line_open) send_advance();
      if ($urandom_range(0, 7) == 0) send_advance();
    end
  endtask

  // An advance straight after reset finds no line.
  task automatic test_idle_advance();
    send_advance();
    send_advance();
  endtask

  // Equal endpoints give one final pixel and leave no line behind.
  task automatic test_single_point();
    send_req(REQ_START, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
             coord_t'(COORD_MIN));
    send_advance();
  endtask

  // A short horizontal line run to its end and one step past it.
  task automatic test_short_line();
    send_req(REQ_START, coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MIN + 3),
             coord_t'(COORD_MAX));
    repeat (4) send_advance();
  endtask

  // A corner-to-corner line is dropped by a steep line that crosses zero going negative.
  task automatic test_restart_mid_line();
    send_req(REQ_START, coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
             coord_t'(COORD_MAX));
    repeat (2) send_advance();
    send_req(REQ_START, coord_t'(1), coord_t'(3), coord_t'(-1), coord_t'(-3));
    while (line_open) send_advance();
  endtask

  task automatic test_random_lines(input int target);
    idle_on = 1'b1;
    while (items_sent < target) draw_random_line(12);
  endtask

  // The receiver holds off while a whole line is offered, so the block backs up.
  task automatic test_receiver_hold();
    idle_on = 1'b0;
    pix_hold_cycles = 300;
    send_req(REQ_START, coord_t'(-100), coord_t'(50), coord_t'(-60), coord_t'(20));
    while (line_open) send_advance();
  endtask

  // Back-to-back requests with an always-ready receiver.
  task automatic test_streaming(input int target);
    idle_on = 1'b0;
    while (items_sent < target) draw_random_line(8);
  endtask

  // Test sequence and end of run.
  initial begin
    line_open    = 1'b0;
    pixels_to_go = '0;
    @(negedge rst);
    @(posedge clk);
    test_idle_advance();
    test_single_point();
    test_short_line();
    test_restart_mid_line();
    wait_for_drain();
    test_random_lines(450);
    test_receiver_hold();
    wait_for_drain();
    test_random_lines(520);
    test_streaming(650);
    wait_for_drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
